@@ sv/rbc_pkg.sv @@
// Shared types and register indexes for the RSA block cipher.
package rbc_pkg;

   typedef struct packed {
      logic busy;
      logic done;
   } rbc_stat_type;

   localparam int unsigned ACC_BITS = 56;
   localparam int unsigned CSR_ADDR_BITS = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXPONENT = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODE     = 2'd2;

   localparam logic [63:0] MODULUS_RESET  = 64'd2;
   localparam logic [63:0] EXPONENT_RESET = 64'd65537;

endpackage

@@ sv/rbc_modmul.sv @@
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle.
module rbc_modmul
   import rbc_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   input  logic [WORD_BITS-1:0] n,
   output logic [WORD_BITS-1:0] prod,
   output rbc_stat_type         stat
);

   logic [WORD_BITS-1:0] r_ff, r_in, a_ff, a_in, b_ff, b_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [WORD_BITS:0]   sum_r, sub_r, sum_a, sub_a;

   always_comb begin
      sum_r = {1'b0, r_ff} + {1'b0, a_ff};
      sub_r = sum_r - {1'b0, n};
      sum_a = {1'b0, a_ff} + {1'b0, a_ff};
      sub_a = sum_a - {1'b0, n};
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = '0;
         a_in    = a;
         b_in    = b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               r_in = (sum_r >= {1'b0, n}) ? sub_r[WORD_BITS-1:0] : sum_r[WORD_BITS-1:0];
            end
            a_in = (sum_a >= {1'b0, n}) ? sub_a[WORD_BITS-1:0] : sum_a[WORD_BITS-1:0];
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod      = r_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ sv/rbc_powmod.sv @@
// Square-and-multiply sequencer with bit-serial input reduction.
module rbc_powmod
   import rbc_pkg::*;
#(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] x,
   input  logic [63:0]          e,
   input  logic [WORD_BITS-1:0] n,
   output logic [WORD_BITS-1:0] res,
   output rbc_stat_type         stat
);

   localparam int unsigned CW = $clog2(WORD_BITS);
   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_RED  = 3'd1;
   localparam logic [2:0] P_CHK  = 3'd2;
   localparam logic [2:0] P_MR   = 3'd3;
   localparam logic [2:0] P_MS   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [WORD_BITS-1:0] r_ff, r_in, b_ff, b_in, x_ff, x_in;
   logic [63:0]          e_ff, e_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   red_s, red_d;
   logic                 mul_start;
   logic [WORD_BITS-1:0] mul_a, prod;
   rbc_stat_type         mstat;

   rbc_modmul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (b_ff),
      .n     (n),
      .prod  (prod),
      .stat  (mstat)
   );

   always_comb begin
      red_s     = {b_ff, x_ff[WORD_BITS-1]};
      red_d     = red_s - {1'b0, n};
      state_in  = state_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      x_in      = x_ff;
      e_in      = e_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      mul_start = 1'b0;
      mul_a     = b_ff;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               if (n[WORD_BITS-1:1] == '0) begin
                  r_in    = '0;
                  done_in = 1'b1;
               end else begin
                  r_in     = {{(WORD_BITS-1){1'b0}}, 1'b1};
                  b_in     = '0;
                  x_in     = x;
                  e_in     = e;
                  cnt_in   = CW'(WORD_BITS - 1);
                  state_in = P_RED;
               end
            end
         end
         P_RED: begin
            b_in   = (red_s >= {1'b0, n}) ? red_d[WORD_BITS-1:0] : red_s[WORD_BITS-1:0];
            x_in   = x_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = P_CHK;
            end
         end
         P_CHK: begin
            if (e_ff == '0) begin
               done_in  = 1'b1;
               state_in = P_IDLE;
            end else if (!mstat.busy) begin
               mul_start = 1'b1;
               if (e_ff[0]) begin
                  mul_a    = r_ff;
                  state_in = P_MR;
               end else begin
                  state_in = P_MS;
               end
            end
         end
         P_MR: begin
            if (mstat.done) begin
               r_in      = prod;
               mul_start = 1'b1;
               state_in  = P_MS;
            end
         end
         P_MS: begin
            if (mstat.done) begin
               b_in     = prod;
               e_in     = e_ff >> 1;
               state_in = P_CHK;
            end
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      e_ff   <= e_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign res       = r_ff;
   assign stat.busy = (state_ff != P_IDLE);
   assign stat.done = done_ff;

endmodule

@@ sv/rsa_block_cipher_64.sv @@
// Top level: byte packing, block control, result unpacking and stream ports.
// Per block: a bit-serial reduction of the input word, then per exponent bit a squaring plus a
// multiply for a set bit, each run on the bit-serial multiplier.
// One item is in flight at a time; throughput is set by the shared bit-serial
// multiplier. A result beat waits in the output register while the next item enters.
// Reset restores modulus, exponent, mode, FSM, block fill and flags; not the data registers.
module rsa_block_cipher_64
   import rbc_pkg::*;
#(
   parameter int unsigned WORD_BITS       = 64,
   parameter int unsigned MAX_BLOCK_BYTES = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [63:0]              req_tdata,   // data
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [63:0]              rsp_tdata,   // data_res
   output logic [1:0]               rsp_tuser,   // [1] end_of_message, [0] terminator
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [63:0]              csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EPUSH = 3'd1;
   localparam logic [2:0] S_EPAD  = 3'd2;
   localparam logic [2:0] S_POW   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   localparam logic [1:0] PH_BYTE = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_PAD  = 2'd2;
   localparam logic [1:0] PH_DEC  = 2'd3;

   logic [63:0]          modulus_ff, exponent_ff;
   logic                 mode_ff;
   logic [2:0]           state_ff, state_in;
   logic [1:0]           ph_ff, ph_in;
   logic [63:0]          data_ff, data_in;
   logic                 last_ff, last_in;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 seen_ff, seen_in;
   logic [2:0]           idx_ff, idx_in;
   logic                 vld_ff, vld_in, rlast_ff, rlast_in;
   logic [63:0]          rdata_ff, rdata_in;
   logic [1:0]           ruser_ff, ruser_in;

   logic [WORD_BITS-1:0] n, q, pow_res;
   logic [2:0]           blk, cnt_n, pad_bytes, idx_m1;
   logic [ACC_BITS-1:0]  push_acc, pad_acc;
   logic [63:0]          pow_x, mword;
   logic [7:0]           push_byte, dbyte;
   logic                 pow_start, out_free, close, fin, accept;
   rbc_stat_type         pstat;

   rbc_powmod #(.WORD_BITS(WORD_BITS)) u_pow (
      .clock (clock),
      .reset (reset),
      .start (pow_start),
      .x     (pow_x[WORD_BITS-1:0]),
      .e     (exponent_ff),
      .n     (n),
      .res   (pow_res),
      .stat  (pstat)
   );

   assign n = modulus_ff[WORD_BITS-1:0];

   always_comb begin
      q   = (n - 1'b1) >> 8;
      blk = '0;
      for (int k = 0; k < int'(MAX_BLOCK_BYTES); k++) begin
         if ((q >> (8 * k)) != '0) begin
            blk = blk + 3'd1;
         end
      end
      if (n[WORD_BITS-1:1] == '0 || blk == '0) begin
         blk = 3'd1;
      end
   end

   always_comb begin
      accept    = req_tvalid && req_tready;
      out_free  = !vld_ff || rsp_tready;
      push_byte = (ph_ff == PH_BYTE) ? data_ff[7:0] : 8'd0;
      push_acc  = {acc_ff[ACC_BITS-9:0], push_byte};
      cnt_n     = cnt_ff + 3'd1;
      close     = (cnt_n >= blk) || (cnt_n == 3'd7);
      pad_bytes = (cnt_ff < blk) ? (blk - cnt_ff) : 3'd0;
      pad_acc   = acc_ff << {pad_bytes, 3'b000};
      mword     = 64'(pow_res);
      idx_m1    = idx_ff - 3'd1;
      dbyte     = mword[{idx_m1, 3'b000} +: 8];
      fin       = 1'b0;
      pow_start = 1'b0;
      pow_x     = req_tdata;
      state_in  = state_ff;
      ph_in     = ph_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      seen_in   = seen_ff;
      idx_in    = idx_ff;
      vld_in    = vld_ff && !rsp_tready;
      rdata_in  = rdata_ff;
      ruser_in  = ruser_ff;
      rlast_in  = rlast_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in = req_tdata;
               last_in = req_tlast;
               if (!mode_ff) begin
                  ph_in    = PH_BYTE;
                  state_in = S_EPUSH;
               end else if (!seen_ff) begin
                  pow_start = 1'b1;
                  ph_in     = PH_DEC;
                  state_in  = S_POW;
               end else if (req_tlast) begin
                  seen_in = 1'b0;
               end
            end
         end
         S_EPUSH: begin
            if (close) begin
               pow_x     = 64'(push_acc);
               pow_start = 1'b1;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = S_POW;
            end else begin
               acc_in = push_acc;
               cnt_in = cnt_n;
               if (ph_ff == PH_BYTE && last_ff) begin
                  ph_in = PH_ZERO;
               end else if (ph_ff == PH_ZERO) begin
                  state_in = S_EPAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EPAD: begin
            pow_x     = 64'(pad_acc);
            pow_start = 1'b1;
            acc_in    = '0;
            cnt_in    = '0;
            ph_in     = PH_PAD;
            state_in  = S_POW;
         end
         S_POW: begin
            if (pstat.done) begin
               idx_in   = blk;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               vld_in = 1'b1;
               if (ph_ff != PH_DEC) begin
                  fin      = (ph_ff == PH_BYTE) ? !last_ff : 1'b1;
                  rdata_in = mword;
                  ruser_in = {last_ff && fin, 1'b0};
                  rlast_in = fin;
                  if (ph_ff == PH_BYTE && last_ff) begin
                     ph_in    = PH_ZERO;
                     state_in = S_EPUSH;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else if (idx_ff == '0) begin
                  rdata_in = '0;
                  ruser_in = 2'b11;
                  rlast_in = 1'b1;
                  seen_in  = 1'b0;
                  state_in = S_IDLE;
               end else if (dbyte == 8'd0) begin
                  rdata_in = '0;
                  ruser_in = 2'b11;
                  rlast_in = 1'b1;
                  seen_in  = !last_ff;
                  state_in = S_IDLE;
               end else begin
                  fin      = (idx_ff == 3'd1) && !last_ff;
                  rdata_in = 64'(dbyte);
                  ruser_in = 2'b00;
                  rlast_in = fin;
                  idx_in   = idx_m1;
                  if (fin) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      rdata_ff <= rdata_in;
      ruser_ff <= ruser_in;
      rlast_ff <= rlast_in;
      if (reset) begin
         modulus_ff  <= MODULUS_RESET;
         exponent_ff <= EXPONENT_RESET;
         mode_ff     <= 1'b0;
         state_ff    <= S_IDLE;
         ph_ff       <= PH_BYTE;
         acc_ff      <= '0;
         cnt_ff      <= '0;
         seen_ff     <= 1'b0;
         vld_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         seen_ff  <= seen_in;
         vld_ff   <= vld_in;
         if (csr_valid) begin
            unique case (csr_addr)
               CSR_MODULUS:  modulus_ff  <= csr_wdata;
               CSR_EXPONENT: exponent_ff <= csr_wdata;
               CSR_MODE:     mode_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !pstat.busy;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
   assign rsp_tlast  = rlast_ff;

endmodule

@@ verif/rsa_block_cipher_64_checker.sv @@
// Checker for rsa_block_cipher_64: watches all channels, predicts ciphertext/plaintext beats.
module rsa_block_cipher_64_checker
   import rbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [63:0]              req_tdata,
   input  logic                     req_tlast,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [63:0]              rsp_tdata,
   input  logic [1:0]               rsp_tuser,
   input  logic                     rsp_tlast,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [63:0]              csr_wdata,
   output int                       fail_count,
   output int                       outstanding,
   output int                       beats_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] data;
      logic        term;
      logic        eom;
      logic        run_end;
   } cipher_beat_type;

   cipher_beat_type expected_beats[$];

   logic [63:0] key_mod;
   logic [63:0] key_exp;
   logic        decrypt_mode;
   logic [55:0] block_acc;
   logic [2:0]  block_fill;
   logic        term_seen;

   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
      logic [63:0] r;
      r = '0;
      while (b != 0) begin
         if (b[0]) r = (r >= n - a) ? r - (n - a) : r + a;
         a = (a >= n - a) ? a - (n - a) : a + a;
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] x);
      logic [63:0] r, base, e;
      if (key_mod < 2) return '0;
      base = x % key_mod;
      e = key_exp;
      r = 64'd1;
      while (e != 0) begin
         if (e[0]) r = mul_mod(r, base, key_mod);
         base = mul_mod(base, base, key_mod);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic int unsigned block_len();
      logic [63:0] q, t;
      int unsigned b;
      if (key_mod < 2) return 1;
      q = (key_mod - 1) / 256;
      t = 64'd1;
      b = 0;
      while (b < 7 && t <= q) begin
         t = t * 256;
         b++;
      end
      return (b < 1) ? 1 : b;
   endfunction

   task automatic add_beat(logic [63:0] d, logic term, logic eom);
      expected_beats.push_back('{data: d, term: term, eom: eom, run_end: 1'b0});
   endtask

   task automatic pack_byte(logic [7:0] b);
      block_acc = {block_acc[47:0], b};
      block_fill = block_fill + 3'd1;
      if (block_fill >= block_len() || block_fill == 3'd7) begin
         add_beat(pow_mod({8'd0, block_acc}), 1'b0, 1'b0);
         block_acc = '0;
         block_fill = '0;
      end
   endtask

   task automatic predict(logic [63:0] d, logic last);
      int unsigned first, blk;
      logic [63:0] m;
      logic [7:0] b;
      first = expected_beats.size();
      if (!decrypt_mode) begin
         pack_byte(d[7:0]);
         if (last) begin
            pack_byte(8'd0);
            if (block_fill > 0) begin
               blk = block_len();
               m = {8'd0, block_acc};
               if (block_fill < blk) m = m << (8 * (blk - block_fill));
               add_beat(pow_mod(m), 1'b0, 1'b0);
               block_acc = '0;
               block_fill = '0;
            end
            if (expected_beats.size() > first) expected_beats[$].eom = 1'b1;
         end
      end else begin
         if (!term_seen) begin
            blk = block_len();
            m = pow_mod(d);
            for (int i = blk; i > 0; i--) begin
               b = 8'(m >> (8 * (i - 1)));
               if (b == 0) begin
                  add_beat(64'd0, 1'b1, 1'b1);
                  term_seen = 1'b1;
                  break;
               end
               add_beat({56'd0, b}, 1'b0, 1'b0);
            end
            if (last && !term_seen) add_beat(64'd0, 1'b1, 1'b1);
         end
         if (last) term_seen = 1'b0;
      end
      if (expected_beats.size() > first) expected_beats[$].run_end = 1'b1;
   endtask

   always @(posedge clock) begin
      cipher_beat_type want, got;
      if (reset) begin
         key_mod = MODULUS_RESET;
         key_exp = EXPONENT_RESET;
         decrypt_mode = 1'b0;
         block_acc = '0;
         block_fill = '0;
         term_seen = 1'b0;
         expected_beats.delete();
         fail_count = 0;
         beats_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_MODULUS:  key_mod = csr_wdata;
               CSR_EXPONENT: key_exp = csr_wdata;
               CSR_MODE:     decrypt_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{data: rsp_tdata, term: rsp_tuser[0], eom: rsp_tuser[1], run_end: rsp_tlast};
            beats_seen++;
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected beat: %h", got);
            end else begin
               want = expected_beats.pop_front();
               if (want !== got) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"beat %0d: expected data=%h term=%b eom=%b last=%b, ",
                        "got data=%h term=%b eom=%b last=%b"},
                        beats_seen, want.data, want.term, want.eom, want.run_end,
                        got.data, got.term, got.eom, got.run_end);
               end
            end
         end
         if (req_tvalid && req_tready) predict(req_tdata, req_tlast);
      end
      outstanding = expected_beats.size();
   end
endmodule

@@ verif/rsa_block_cipher_64_tb.sv @@
// Testbench top for rsa_block_cipher_64: clock, reset, stimulus and verdict.
module rsa_block_cipher_64_tb;
   import rbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DRAIN_CYCLES = 9000;
   localparam longint unsigned CYCLE_LIMIT = 20_000_000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [63:0]              req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [63:0]              rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [63:0]              csr_wdata = '0;

   int fail_count, outstanding, beats_seen;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int items_sent = 0;
   longint unsigned cycle_count = 0;

   rsa_block_cipher_64 u_top (.*);

   rsa_block_cipher_64_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("rsa_block_cipher_64: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [63:0] value);
      csr_valid = 1'b1;
      csr_addr = addr;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_item(logic [63:0] data, logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = data;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic settle();
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_key(logic [63:0] modulus, logic [63:0] exponent, logic mode);
      settle();
      csr_write(CSR_MODULUS, modulus);
      csr_write(CSR_EXPONENT, exponent);
      csr_write(CSR_MODE, {63'd0, mode});
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_modulus();
      logic [63:0] n;
      case ($urandom_range(0, 3))
         0: n = 64'($urandom_range(2, 300));
         1: n = 64'($urandom_range(257, 70000));
         2: n = rand_word() >> $urandom_range(0, 40);
         default: n = rand_word();
      endcase
      return (n < 2) ? 64'd2 : n;
   endfunction

   function automatic logic [63:0] rand_exponent();
      case ($urandom_range(0, 4))
         0: return rand_word();
         1: return 64'd0;
         default: return 64'($urandom_range(1, 40));
      endcase
   endfunction

   // plaintext word with mostly nonzero bytes so messages run across several words
   function automatic logic [63:0] message_word();
      logic [63:0] w;
      for (int i = 0; i < 8; i++)
         w[8*i +: 8] = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      return w;
   endfunction

   task automatic random_phase(int count, int idle_pct, int stall_pct, bit pressure);
      logic mode;
      logic [63:0] exponent;
      mode = 1'($urandom_range(0, 1));
      exponent = pressure ? 64'd3 : rand_exponent();
      if (mode && !pressure && $urandom_range(0, 2) != 0) exponent = 64'd1;
      set_key(rand_modulus(), exponent, mode);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (pressure) hold_off_cycles = 4000;
      for (int i = 0; i < count; i++) begin
         if (mode && $urandom_range(0, 4) != 0)
            send_item(message_word(), $urandom_range(0, 3) == 0);
         else
            send_item(rand_word(), $urandom_range(0, 6) == 0);
      end
      send_item(rand_word(), 1'b1);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset key: modulus 2, one-byte blocks
      send_item(64'h0, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(64'h41, 1'b1);

      // full-width modulus, zero exponent
      set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0);
      for (int i = 0; i < 6; i++) send_item(64'h11 * (i + 1), 1'b0);
      send_item(64'hFF, 1'b1);

      // decrypt: zero word, words after terminator, data above modulus
      set_key(64'h10001, 64'd1, 1'b1);
      send_item(64'h0, 1'b0);
      send_item(64'h4142, 1'b0);
      send_item(64'h4142, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_item(64'h1_4142, 1'b1);

      // modulus shrinks mid-block, mode flips mid-message
      set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      for (int i = 0; i < 3; i++) send_item(64'h61 + i, 1'b0);
      set_key(64'h10001, 64'd5, 1'b0);
      send_item(64'h64, 1'b0);
      set_key(64'h10001, 64'd5, 1'b1);
      send_item(64'h0102, 1'b0);
      set_key(64'h10001, 64'd5, 1'b0);
      send_item(64'h65, 1'b1);

      random_phase(18, 0, 0, 1'b1);
      random_phase(18, 49, 0, 1'b0);
      random_phase(18, 0, 49, 1'b0);
      random_phase(18, 38, 38, 1'b0);
      random_phase(6, 0, 0, 1'b0);

      settle();
      $display("sent %0d input beats over encrypt and decrypt keys, checked %0d result beats",
         items_sent, beats_seen);
      $display("covered idle and stall mixes, a long receiver hold-off and mid-message key changes");
      if (fail_count == 0 && outstanding == 0) begin
         $display("rsa_block_cipher_64: match");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, outstanding);
         $display("rsa_block_cipher_64: mismatch");
      end
      $finish;
   end
endmodule
